// File: rtl/vtep_pkg.sv
// ============================================================================
// vtep_pkg
// Types and constants shared by the text event parser modules.
// ============================================================================
`default_nettype none

package vtep_pkg;

   // Input beat: one text character or the end-of-message marker
   typedef struct packed {
      logic [7:0] character;
      logic       is_end;
   } req_type;

   // Result beat: one parsed event
   typedef struct packed {
      logic        status;
      logic [7:0]  head;
      logic [8:0]  event_class;
      logic [7:0]  event_type;
      logic        is_level2;
      logic [3:0]  data_length;
      logic [63:0] data_bytes;
   } rsp_type;

   // Classified character, front to back
   typedef struct packed {
      logic       is_end;
      logic       is_comma;
      logic       is_x;       // lowercase x, hex prefix candidate
      logic       is_dec;     // 0..9
      logic       is_alpha;   // a..f or A..F
      logic       is_zero;    // the character 0
      logic [3:0] digit;      // digit value for is_dec or is_alpha
   } cls_type;

   // CSR indexes
   localparam logic CSR_GUID_HIGH = 1'b0;
   localparam logic CSR_GUID_LOW  = 1'b1;

   // Field numbers
   localparam logic [4:0] FIELD_HEAD     = 5'd0;
   localparam logic [4:0] FIELD_CLASS    = 5'd1;
   localparam logic [4:0] FIELD_TYPE     = 5'd2;
   localparam logic [4:0] FIELD_DATA0    = 5'd7;   // first field after the skipped ones
   localparam logic [4:0] FIELD_L2_DATA0 = 5'd23;  // first level 2 data field
   localparam logic [4:0] FIELD_LAST     = 5'd30;  // last numeric field
   localparam logic [4:0] FIELD_OVER     = 5'd31;  // field count overflow
   localparam logic [4:0] MIN_FIELDS     = 5'd7;

   localparam logic [13:0] VALUE_MAX   = 14'd1023;
   localparam logic [9:0]  BYTE_MAX    = 10'd255;
   localparam logic [9:0]  LEVEL2_BASE = 10'd512;

   localparam logic [1:0] CIF_MAX = 2'd3;

   function automatic logic is_numeric(input logic [4:0] f);
      is_numeric = (f <= FIELD_TYPE) || ((f >= FIELD_DATA0) && (f <= FIELD_LAST));
   endfunction

endpackage

`default_nettype wire

// File: rtl/vtep_fifo.sv
// ============================================================================
// vtep_fifo
// Small register queue with push/full and pop/empty handshakes.
// ============================================================================
`default_nettype none

module vtep_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/vtep_front.sv
// ============================================================================
// vtep_front
// Accepts character beats, classifies them and queues them for the back end.
// ============================================================================
`default_nettype none

module vtep_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire vtep_pkg::req_type req_beat,
   input  wire logic              cmd_pop,
   output logic                   cmd_empty,
   output vtep_pkg::cls_type      cmd_beat
);

   import vtep_pkg::*;

   localparam int CW = $bits(cls_type);

   cls_type      cls;
   logic [7:0]   c;
   logic [7:0]   c_low;
   logic [CW-1:0] rd_vec;

   assign c     = req_beat.character;
   assign c_low = c | 8'h20;  // fold A..F onto a..f

   always_comb begin
      cls          = '0;
      cls.is_end   = req_beat.is_end;
      cls.is_comma = (c == 8'h2C);
      cls.is_x     = (c == 8'h78);
      cls.is_dec   = (c >= 8'h30) && (c <= 8'h39);
      cls.is_alpha = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
      cls.is_zero  = (c == 8'h30);
      if (cls.is_dec) begin
         cls.digit = c[3:0];
      end else begin
         cls.digit = 4'(c_low - 8'h57);  // a -> 10
      end
   end

   vtep_fifo #(
      .WIDTH (CW),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_data (cls),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (rd_vec)
   );

   assign cmd_beat = cls_type'(rd_vec);

endmodule

`default_nettype wire

// File: rtl/vtep_back.sv
// ============================================================================
// vtep_back
// Parser state: field tracking, number accumulation, checks and result build.
// ============================================================================
`default_nettype none

module vtep_back #(
   parameter int MAX_DATA_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [63:0]       csr_wdata,
   input  wire logic              cmd_empty,
   input  wire vtep_pkg::cls_type cmd_beat,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output vtep_pkg::rsp_type      rsp_beat
);

   import vtep_pkg::*;

   localparam int DATA_W = 8 * MAX_DATA_BYTES;
   localparam int CNT_W  = $clog2(MAX_DATA_BYTES + 1);
   localparam int PAD    = 64 - DATA_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DATA_BYTES);

   logic [63:0]       guid_high_ff, guid_low_ff;
   logic [4:0]        field_ff, field_in;
   logic [1:0]        cif_ff, cif_in;
   logic              hex_ff, hex_in;
   logic              fz_ff, fz_in;
   logic              seen_ff, seen_in;
   logic [9:0]        acc_ff, acc_in;
   logic              big_ff, big_in;
   logic              err_ff, err_in;
   logic              lvl2_ff, lvl2_in;
   logic [7:0]        head_ff, head_in;
   logic [8:0]        class_ff, class_in;
   logic [7:0]        type_ff, type_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // field close results
   logic              fin_err;
   logic              fin_lvl2;
   logic [7:0]        fin_head, fin_type, gbyte;
   logic [8:0]        fin_class;
   logic [DATA_W-1:0] fin_data;
   logic [CNT_W-1:0]  fin_cnt;
   logic [4:0]        fin_field;
   logic [3:0]        gidx;
   logic [127:0]      guid_all;
   logic              store;

   logic              numeric, digit_ok, do_finish, fail;
   logic [13:0]       next_val;
   logic [1:0]        cif_inc;

   assign guid_all = {guid_high_ff, guid_low_ff};
   assign gidx     = 4'(field_ff - FIELD_DATA0);
   assign numeric  = is_numeric(field_ff);
   assign cif_inc  = (cif_ff == CIF_MAX) ? CIF_MAX : cif_ff + 2'd1;

   always_comb begin
      gbyte = '0;
      for (int k = 0; k < 16; k++) begin
         if (gidx == 4'(k)) begin
            gbyte = guid_all[(15 - k) * 8 +: 8];
         end
      end
   end

   // close of the current field, as on a comma
   always_comb begin
      fin_err   = 1'b0;
      fin_lvl2  = lvl2_ff;
      fin_head  = head_ff;
      fin_class = class_ff;
      fin_type  = type_ff;
      fin_data  = data_ff;
      fin_cnt   = cnt_ff;
      store     = 1'b0;
      if (field_ff == FIELD_OVER) begin
         fin_err = 1'b1;
      end else if (numeric) begin
         if (!seen_ff) begin
            fin_err = 1'b1;
         end else begin
            case (field_ff)
               FIELD_HEAD: begin
                  if (big_ff || acc_ff > BYTE_MAX) fin_err = 1'b1;
                  else fin_head = acc_ff[7:0];
               end
               FIELD_CLASS: begin
                  if (big_ff) begin
                     fin_err = 1'b1;
                  end else begin
                     // below 1024, so dropping bit 9 removes the 512
                     fin_class = acc_ff[8:0];
                     fin_lvl2  = (acc_ff >= LEVEL2_BASE);
                  end
               end
               FIELD_TYPE: begin
                  if (big_ff || acc_ff > BYTE_MAX) fin_err = 1'b1;
                  else fin_type = acc_ff[7:0];
               end
               default: begin
                  if (lvl2_ff && field_ff < FIELD_L2_DATA0) begin
                     if (big_ff || acc_ff != {2'b00, gbyte}) fin_err = 1'b1;
                  end else begin
                     store = 1'b1;
                  end
               end
            endcase
         end
      end
      if (store) begin
         if (acc_ff > BYTE_MAX || big_ff || cnt_ff >= CNT_MAX) begin
            fin_err = 1'b1;
         end else begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
               if (cnt_ff == CNT_W'(i)) begin
                  fin_data[(MAX_DATA_BYTES - 1 - i) * 8 +: 8] = acc_ff[7:0];
               end
            end
            fin_cnt = cnt_ff + 1'b1;
         end
      end
      fin_field = (field_ff == FIELD_OVER) ? FIELD_OVER : field_ff + 5'd1;
   end

   // digit accumulate
   assign digit_ok = cmd_beat.is_dec || (hex_ff && cmd_beat.is_alpha);
   always_comb begin
      if (hex_ff) begin
         next_val = {acc_ff, 4'b0000} + 14'(cmd_beat.digit);
      end else begin
         next_val = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 14'(cmd_beat.digit);
      end
   end

   // an end beat waits for room in the result queue
   assign cmd_pop   = !cmd_empty && (!cmd_beat.is_end || !rsp_full);
   assign rsp_push  = cmd_pop && cmd_beat.is_end;
   assign do_finish = !err_ff && (cif_ff != 2'd0);

   always_comb begin
      if (do_finish) begin
         fail = fin_err || (fin_field < MIN_FIELDS);
      end else begin
         fail = err_ff || (field_ff < MIN_FIELDS);
      end
      rsp_beat = '0;
      rsp_beat.status = fail;
      if (!fail) begin
         rsp_beat.head        = do_finish ? fin_head  : head_ff;
         rsp_beat.event_class = do_finish ? fin_class : class_ff;
         rsp_beat.event_type  = do_finish ? fin_type  : type_ff;
         rsp_beat.is_level2   = do_finish ? fin_lvl2  : lvl2_ff;
         rsp_beat.data_length = 4'(do_finish ? fin_cnt : cnt_ff);
         rsp_beat.data_bytes  = 64'(do_finish ? fin_data : data_ff) << PAD;
      end
   end

   always_comb begin
      field_in = field_ff;
      cif_in   = cif_ff;
      hex_in   = hex_ff;
      fz_in    = fz_ff;
      seen_in  = seen_ff;
      acc_in   = acc_ff;
      big_in   = big_ff;
      err_in   = err_ff;
      lvl2_in  = lvl2_ff;
      head_in  = head_ff;
      class_in = class_ff;
      type_in  = type_ff;
      data_in  = data_ff;
      cnt_in   = cnt_ff;
      if (cmd_pop) begin
         if (cmd_beat.is_end) begin
            field_in = '0;
            cif_in   = '0;
            hex_in   = 1'b0;
            fz_in    = 1'b0;
            seen_in  = 1'b0;
            acc_in   = '0;
            big_in   = 1'b0;
            err_in   = 1'b0;
            lvl2_in  = 1'b0;
            head_in  = '0;
            class_in = '0;
            type_in  = '0;
            data_in  = '0;
            cnt_in   = '0;
         end else if (!err_ff) begin
            if (cmd_beat.is_comma) begin
               err_in   = fin_err;
               lvl2_in  = fin_lvl2;
               head_in  = fin_head;
               class_in = fin_class;
               type_in  = fin_type;
               data_in  = fin_data;
               cnt_in   = fin_cnt;
               field_in = fin_field;
               cif_in   = '0;
               hex_in   = 1'b0;
               fz_in    = 1'b0;
               seen_in  = 1'b0;
               acc_in   = '0;
               big_in   = 1'b0;
            end else if (!numeric) begin
               cif_in = cif_inc;
            end else if (cif_ff == 2'd1 && fz_ff && !hex_ff && cmd_beat.is_x) begin
               // 0x prefix
               hex_in  = 1'b1;
               seen_in = 1'b0;
               acc_in  = '0;
               cif_in  = 2'd2;
            end else if (digit_ok) begin
               if (cif_ff == 2'd0) fz_in = cmd_beat.is_zero;
               cif_in  = cif_inc;
               seen_in = 1'b1;
               if (!big_ff) begin
                  if (next_val > VALUE_MAX) big_in = 1'b1;
                  else acc_in = next_val[9:0];
               end
            end else begin
               err_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guid_high_ff <= '0;
         guid_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GUID_HIGH: guid_high_ff <= csr_wdata;
            CSR_GUID_LOW:  guid_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= '0;
         cif_ff   <= '0;
         hex_ff   <= 1'b0;
         fz_ff    <= 1'b0;
         seen_ff  <= 1'b0;
         acc_ff   <= '0;
         big_ff   <= 1'b0;
         err_ff   <= 1'b0;
         lvl2_ff  <= 1'b0;
         head_ff  <= '0;
         class_ff <= '0;
         type_ff  <= '0;
         data_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         field_ff <= field_in;
         cif_ff   <= cif_in;
         hex_ff   <= hex_in;
         fz_ff    <= fz_in;
         seen_ff  <= seen_in;
         acc_ff   <= acc_in;
         big_ff   <= big_in;
         err_ff   <= err_in;
         lvl2_ff  <= lvl2_in;
         head_ff  <= head_in;
         class_ff <= class_in;
         type_ff  <= type_in;
         data_ff  <= data_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/vscp_text_event_parser.sv
// ============================================================================
// vscp_text_event_parser
// Parses a comma-separated text event, one character beat at a time.
// ============================================================================
// Push one character per beat, then a beat with is_end set; that end beat
// yields exactly one result beat, other beats yield none. Fields 0..2 (head,
// class, type) and 7 onward are unsigned decimal or lowercase-0x hex numbers;
// fields 3..6 are skipped. A class of 512..1023 means level 2: class is
// reported minus 512, fields 7..22 must match the GUID written through the
// CSR port (index 0 = bytes 0..7, index 1 = bytes 8..15, byte 0 in the top
// bits), and data starts at field 23; at level 1 data starts at field 7.
// Any bad character, GUID mismatch, empty numeric field, value too wide,
// extra data byte or fewer than 7 fields sets status and zeroes every other
// result field. Throughput is one beat per clock: the front classifies and
// queues each character, the back updates the parser state once per beat.
// An end beat stalls in the back only while the result queue is full. The
// result of an end beat passes through the character queue, then the result
// queue. Write CSRs only while the block is idle.
// ============================================================================
`default_nettype none

module vscp_text_event_parser #(
   parameter int MAX_DATA_BYTES = 8,   // data bytes kept per event, 1..8
   parameter int QUEUE_DEPTH    = 2    // depth of the internal queues, >= 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // character beats
   input  wire logic              push,
   output logic                   full,
   input  wire vtep_pkg::req_type req_beat,
   // result beats
   output logic                   empty,
   input  wire logic              pop,
   output vtep_pkg::rsp_type      rsp_beat,
   // CSR write port
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [63:0]       csr_wdata
);

   import vtep_pkg::*;

   localparam int RW = $bits(rsp_type);

   cls_type       cmd_beat;
   logic          cmd_empty, cmd_pop;
   logic          rsp_push, rsp_full;
   rsp_type       rsp_wr;
   logic [RW-1:0] rsp_vec;

   // front: classify and queue characters
   vtep_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_beat  (req_beat),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_beat  (cmd_beat)
   );

   // back: parser state and result build
   vtep_back #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_beat  (cmd_beat),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_beat  (rsp_wr)
   );

   // result queue decouples the back from the consumer
   vtep_fifo #(
      .WIDTH (RW),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (rsp_wr),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_vec)
   );

   assign rsp_beat = rsp_type'(rsp_vec);

endmodule

`default_nettype wire
